FILE: rtl/core/brfe_pkg.sv
package brfe_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int FRAME_MAX = 128;
  localparam int FRAME_AW = $clog2(FRAME_MAX);
  localparam int FRAME_LW = $clog2(FRAME_MAX + 1);
  localparam int OVERHEAD = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_PENDING  = 3'd2,
    ST_INCOMPL  = 3'd3,
    ST_EXTRACT  = 3'd4
  } status_t;

  localparam logic [CFG_AW-1:0] REG_HDR0 = 4'h0;
  localparam logic [CFG_AW-1:0] REG_HDR1 = 4'h4;
  localparam logic [CFG_AW-1:0] REG_VER  = 4'h8;
  localparam logic [CFG_AW-1:0] REG_MAXP = 4'hC;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_EXEC,
    BS_HCHK,
    BS_H0,
    BS_H1,
    BS_H2,
    BS_H4,
    BS_H5,
    BS_HEVAL,
    BS_COPY_RD,
    BS_COPY_WR,
    BS_OUT
  } bstate_t;

  // Decoded word handed from the front to the back.
  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        data_byte;
    logic [FRAME_AW-1:0] frame_index;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_data;
    logic [7:0] frame_length;
    logic [7:0] fill_level;
  } res_word_t;

endpackage

FILE: rtl/core/brfe_if.sv
interface brfe_in_if;
  import brfe_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [6:0] frame_index;
  modport source (output valid, command, data_byte, frame_index, input ready);
  modport sink (input valid, command, data_byte, frame_index, output ready);
endinterface

interface brfe_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] read_data;
  logic [7:0] frame_length;
  logic [7:0] fill_level;
  modport source (output valid, status, read_data, frame_length, fill_level, input ready);
  modport sink (input valid, status, read_data, frame_length, fill_level, output ready);
endinterface

FILE: rtl/core/brfe_front.sv
module brfe_front
  import brfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  brfe_in_if.sink   in_ch,
  output logic      q_valid,
  output cmd_word_t q_word,
  input  logic      q_pop
);

  cmd_word_t mem_r [QUEUE_DEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push;

  // Accept a word whenever the queue has room.
  assign in_ch.ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_word = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the command word on entry.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].cmd <= cmd_t'(in_ch.command);
      mem_r[wp_r].data_byte <= in_ch.data_byte;
      mem_r[wp_r].frame_index <= in_ch.frame_index;
    end
  end

endmodule

FILE: rtl/core/brfe_back.sv
module brfe_back
  import brfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_word_t  q_word,
  output logic       q_pop,
  input  logic [7:0] hdr0,
  input  logic [7:0] hdr1,
  input  logic [7:0] ver,
  input  logic [6:0] maxp,
  output logic       res_valid,
  output res_word_t  res_word,
  input  logic       res_ready
);

  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] frame_mem [FRAME_MAX];
  logic [7:0] ring_q, frame_q;
  logic [RING_AW-1:0] ring_raddr;

  bstate_t st_r, st_nxt;
  cmd_word_t cw_r;
  logic [RING_AW-1:0] rdp_r, rdp_nxt, wrp_r, wrp_nxt;
  logic               pend_r, pend_nxt;
  logic [FRAME_LW-1:0] plen_r, plen_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic [7:0]          rdat_r, rdat_nxt;
  logic [7:0]          b4_r, b4_nxt;
  logic                bad_r, bad_nxt;
  logic [FRAME_LW-1:0] cpi_r, cpi_nxt;
  logic                out_v_r;
  logic                res_load;
  logic [RING_AW-1:0]  held;
  logic [6:0]          limit;
  logic [15:0]         flen;
  logic                ring_we, frame_we;

  assign held = wrp_r - rdp_r;
  assign limit = (maxp > 7'(FRAME_MAX - OVERHEAD)) ? 7'(FRAME_MAX - OVERHEAD) : maxp;
  assign flen = {b4_r, ring_q};

  // The output register takes a new word once the previous one is gone or leaving.
  assign res_load = (st_r == BS_OUT) && (!out_v_r || res_ready);

  // Ring read address follows the state that issues the peek.
  // The length low byte is held on the read port through the evaluation cycle.
  always_comb begin
    ring_raddr = rdp_r;
    case (st_nxt)
      BS_H1: ring_raddr = rdp_nxt + RING_AW'(1);
      BS_H2: ring_raddr = rdp_nxt + RING_AW'(2);
      BS_H4: ring_raddr = rdp_nxt + RING_AW'(4);
      BS_H5, BS_HEVAL: ring_raddr = rdp_nxt + RING_AW'(5);
      BS_COPY_WR: ring_raddr = rdp_r + RING_AW'(cpi_r);
      default: ring_raddr = rdp_nxt;
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BS_IDLE: if (q_valid) st_nxt = BS_EXEC;
      BS_EXEC: begin
        if (cw_r.cmd == CMD_POLL && !pend_r) st_nxt = BS_HCHK;
        else st_nxt = BS_OUT;
      end
      BS_HCHK: st_nxt = (held >= RING_AW'(OVERHEAD)) ? BS_H0 : BS_OUT;
      BS_H0: st_nxt = BS_H1;
      BS_H1: st_nxt = BS_H2;
      BS_H2: st_nxt = BS_H4;
      BS_H4: st_nxt = BS_H5;
      BS_H5: st_nxt = BS_HEVAL;
      BS_HEVAL: begin
        if (bad_r || flen > 16'(limit)) st_nxt = BS_HCHK;
        else if (held < RING_AW'(flen + 16'(OVERHEAD))) st_nxt = BS_OUT;
        else st_nxt = BS_COPY_RD;
      end
      BS_COPY_RD: st_nxt = BS_COPY_WR;
      BS_COPY_WR: st_nxt = (cpi_r + FRAME_LW'(1) == plen_r) ? BS_OUT : BS_COPY_RD;
      BS_OUT: if (!out_v_r || res_ready) st_nxt = BS_IDLE;
      default: st_nxt = BS_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    rdp_nxt = rdp_r; wrp_nxt = wrp_r; pend_nxt = pend_r; plen_nxt = plen_r;
    stat_nxt = stat_r; rdat_nxt = rdat_r; b4_nxt = b4_r; bad_nxt = bad_r;
    cpi_nxt = cpi_r; ring_we = 1'b0; frame_we = 1'b0; q_pop = 1'b0;
    unique case (st_r)
      BS_IDLE: q_pop = q_valid;
      BS_EXEC: begin
        stat_nxt = ST_OK; rdat_nxt = 8'd0;
        unique case (cw_r.cmd)
          CMD_PUSH: begin
            if (held == RING_AW'(RING_DEPTH - 1)) stat_nxt = ST_FULL;
            else begin
              ring_we = 1'b1;
              wrp_nxt = wrp_r + RING_AW'(1);
            end
          end
          CMD_POLL: if (pend_r) stat_nxt = ST_PENDING;
          CMD_READ: begin
            if (pend_r && FRAME_LW'(cw_r.frame_index) < plen_r) rdat_nxt = frame_q;
          end
          CMD_RELEASE: pend_nxt = 1'b0;
          default: ;
        endcase
      end
      BS_HCHK: begin
        stat_nxt = ST_INCOMPL;
        bad_nxt = 1'b0;
      end
      BS_H0: if (ring_q != hdr0) bad_nxt = 1'b1;
      BS_H1: if (ring_q != hdr1) bad_nxt = 1'b1;
      BS_H2: if (ring_q != ver) bad_nxt = 1'b1;
      BS_H4: b4_nxt = ring_q;
      BS_HEVAL: begin
        if (bad_r || flen > 16'(limit)) rdp_nxt = rdp_r + RING_AW'(1);
        else begin
          plen_nxt = FRAME_LW'(flen + 16'(OVERHEAD));
          cpi_nxt = '0;
        end
      end
      BS_COPY_WR: begin
        frame_we = 1'b1;
        cpi_nxt = cpi_r + FRAME_LW'(1);
        if (cpi_r + FRAME_LW'(1) == plen_r) begin
          rdp_nxt = rdp_r + RING_AW'(plen_r);
          pend_nxt = 1'b1;
          stat_nxt = ST_EXTRACT;
        end
      end
      default: ;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wrp_r] <= cw_r.data_byte;
    ring_q <= ring_mem[ring_raddr];
    if (frame_we) frame_mem[cpi_r[FRAME_AW-1:0]] <= ring_q;
    frame_q <= frame_mem[q_word.frame_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
      rdp_r <= '0; wrp_r <= '0; pend_r <= 1'b0; plen_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rdp_r <= rdp_nxt; wrp_r <= wrp_nxt; pend_r <= pend_nxt; plen_r <= plen_nxt;
      if (res_load) out_v_r <= 1'b1;
      else if (res_valid && res_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cw_r <= q_word;
    stat_r <= stat_nxt; rdat_r <= rdat_nxt; b4_r <= b4_nxt; bad_r <= bad_nxt;
    cpi_r <= cpi_nxt;
    if (res_load) begin
      res_word.status <= stat_r;
      res_word.read_data <= rdat_r;
      res_word.frame_length <= pend_r ? 8'(plen_r) : 8'd0;
      res_word.fill_level <= 8'(held);
    end
  end

  assign res_valid = out_v_r;

endmodule

FILE: rtl/core/brfe_cfg.sv
module brfe_cfg
  import brfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        hdr0,
  output logic [7:0]        hdr1,
  output logic [7:0]        ver,
  output logic [6:0]        maxp
);

  logic [7:0] hdr0_r, hdr1_r, ver_r;
  logic [6:0] maxp_r;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_r <= 8'd0; hdr1_r <= 8'd0; ver_r <= 8'd0; maxp_r <= 7'd121;
    end else if (wr) begin
      unique case (paddr)
        REG_HDR0: hdr0_r <= pwdata[7:0];
        REG_HDR1: hdr1_r <= pwdata[7:0];
        REG_VER:  ver_r <= pwdata[7:0];
        REG_MAXP: maxp_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (paddr)
      REG_HDR0: prdata = {24'd0, hdr0_r};
      REG_HDR1: prdata = {24'd0, hdr1_r};
      REG_VER:  prdata = {24'd0, ver_r};
      REG_MAXP: prdata = {25'd0, maxp_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign hdr0 = hdr0_r;
  assign hdr1 = hdr1_r;
  assign ver = ver_r;
  assign maxp = maxp_r;

endmodule

FILE: rtl/core/byte_ring_frame_extractor.sv
// Byte ring with header-synchronized frame extraction.
// Input channel in_ch carries one command word: push a byte, poll for a
// frame, read a byte of the extracted frame, or release it. Output channel
// out_ch returns exactly one result word per command, in order.
// Commands enter a two-entry queue in the front part; the back sequencer
// executes them one at a time against the 256-byte ring and 128-byte frame
// store, each with one write port and one registered read port.
// A poll scans the ring one start byte at a time (one ring read per peek),
// then copies the frame byte by byte, a ring read and then a store write.
// Reset clears pointers, counts, state, pending flag, frame length and
// output valid; the stores need no clearing. When the receiver stalls, the
// finished word waits in the output register, the sequencer holds, and the
// queue keeps taking up to two words. Configuration is written over the
// APB-style cfg_ port by the user while idle; the block does not enforce it.
module byte_ring_frame_extractor
  import brfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  brfe_in_if.sink           in_ch,
  brfe_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic       q_valid, q_pop, res_valid;
  cmd_word_t  q_word;
  res_word_t  res_word;
  logic [7:0] hdr0, hdr1, ver;
  logic [6:0] maxp;

  brfe_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .hdr0, .hdr1, .ver, .maxp
  );

  brfe_front u_front (.clk, .rst_n, .in_ch, .q_valid, .q_word, .q_pop);

  brfe_back u_back (
    .clk, .rst_n, .q_valid, .q_word, .q_pop, .hdr0, .hdr1, .ver, .maxp,
    .res_valid, .res_word, .res_ready(out_ch.ready)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.status = res_word.status;
  assign out_ch.read_data = res_word.read_data;
  assign out_ch.frame_length = res_word.frame_length;
  assign out_ch.fill_level = res_word.fill_level;

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= 3'd4) else $error("bad status");
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.frame_length <= 8'(FRAME_MAX)) else $error("bad length");
  a_readdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_length == 8'd0) |-> out_ch.read_data == 8'd0)
    else $error("read data without frame");
`endif

endmodule
